@@ hdl/fnps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnps_pkg
// shared types and constants for the nearest point search block
// ----------------------------------------------------------------------------
package fnps_pkg;

  localparam int MaxPoints   = 64;
  localparam int MaxExcluded = 16;
  localparam int CoordBits   = 16;
  localparam int PtIdxBits   = $clog2(MaxPoints);
  localparam int ExIdxBits   = $clog2(MaxExcluded);
  localparam int PtCntBits   = $clog2(MaxPoints + 1);
  localparam int ExCntBits   = $clog2(MaxExcluded + 1);
  // squared distance of two coordinates: (2^CoordBits)^2 * 2
  localparam int DistBits    = 2 * CoordBits + 1;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_EXCL  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOTHING = 2'd2;

  localparam logic [14:0] ExclRadiusReset = 15'd16;

  // colour code to class: codes 0,10,..,100 are classes 0..10, rest 11
  function automatic logic [3:0] color_class(input logic [6:0] code);
    logic [3:0] cls;
    cls = 4'd11;
    for (int k = 0; k <= 10; k++) begin
      if (code == 7'(k * 10)) cls = 4'(k);
    end
    return cls;
  endfunction

  // control from sequencer to the candidate test
  typedef struct packed {
    logic       first;  // no candidate accepted yet
  } dist_ctl_t;

endpackage

@@ hdl/fnps_dist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnps_dist
// shared squared distance unit: axis squares registered, then their sum
// ----------------------------------------------------------------------------
module fnps_dist import fnps_pkg::*; (
  input  logic                        clk,
  input  logic signed [CoordBits-1:0] ax,
  input  logic signed [CoordBits-1:0] ay,
  input  logic signed [CoordBits-1:0] bx,
  input  logic signed [CoordBits-1:0] by,
  output logic        [DistBits-1:0]  dsq
);

  logic [CoordBits:0]       dx_mag, dy_mag;
  logic [2*CoordBits+1:0]   sx_r, sy_r;
  logic [DistBits-1:0]      dsq_r;
  logic signed [CoordBits:0] dx, dy;

  always_comb begin
    dx = (CoordBits+1)'(bx) - (CoordBits+1)'(ax);
    dy = (CoordBits+1)'(by) - (CoordBits+1)'(ay);
    dx_mag = dx[CoordBits] ? (CoordBits+1)'(-dx) : dx;
    dy_mag = dy[CoordBits] ? (CoordBits+1)'(-dy) : dy;
  end

  always_ff @(posedge clk) begin
    sx_r  <= dx_mag * dx_mag;
    sy_r  <= dy_mag * dy_mag;
    dsq_r <= DistBits'(sx_r) + DistBits'(sy_r);
  end

  assign dsq = dsq_r;

endmodule

@@ hdl/filtered_nearest_point_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_nearest_point_search
// nearest stored point search with colour, radius and exclusion filters
// ----------------------------------------------------------------------------
// Adds and clears go from idle through the done state to the output state.
// A query walks the stored points one at a time through a single squared
// distance unit, read at the end of each wait; a point that passes the
// colour, radius and nearer-than-best tests is then checked against each
// exclusion point in turn through the same unit, until one lies within the
// exclusion radius. One request is worked on at a time and in_stall is high
// meanwhile; a finished result holds in the output register until taken.
module filtered_nearest_point_search import fnps_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [14:0]                 cfg_exclude_radius,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic signed [CoordBits-1:0] in_coord_x,
  input  logic signed [CoordBits-1:0] in_coord_y,
  input  logic [6:0]                  in_point_color,
  input  logic [11:0]                 in_color_mask,
  input  logic [14:0]                 in_min_radius,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic signed [CoordBits-1:0] out_near_x,
  output logic signed [CoordBits-1:0] out_near_y,
  output logic [6:0]                  out_near_color
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,  // read point i
    S_PDIST = 7'b0000100,  // wait for point distance
    S_EFET  = 7'b0001000,  // read exclusion j
    S_EDIST = 7'b0010000,  // wait for exclusion distance
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [CoordBits-1:0] px_mem [MaxPoints];
  logic signed [CoordBits-1:0] py_mem [MaxPoints];
  logic [6:0]                  pc_mem [MaxPoints];
  logic signed [CoordBits-1:0] ex_mem [MaxExcluded];
  logic signed [CoordBits-1:0] ey_mem [MaxExcluded];

  logic [PtCntBits-1:0] pcount_r;
  logic [ExCntBits-1:0] ecount_r;
  logic [14:0]          radius_r;

  logic [1:0]                  req_r;
  logic signed [CoordBits-1:0] qx_r, qy_r;
  logic [11:0]                 mask_r;
  logic [29:0]                 rmin_sq_r, rex_sq_r;

  logic [PtCntBits-1:0] pi_r;
  logic [ExCntBits-1:0] ej_r;
  logic [1:0]           wait_r;

  logic signed [CoordBits-1:0] rpx_r, rpy_r, rex_r, rey_r;
  logic [6:0]                  rpc_r;
  logic [DistBits-1:0]         cand_d_r, best_d_r;
  logic                        found_r;
  logic signed [CoordBits-1:0] bx_r, by_r;
  logic [6:0]                  bc_r;

  logic [1:0]                  o_status_r;
  logic signed [CoordBits-1:0] o_x_r, o_y_r;
  logic [6:0]                  o_c_r;

  logic signed [CoordBits-1:0] ua_x, ua_y, ub_x, ub_y;
  logic [DistBits-1:0]         dsq;
  logic                        accept;
  dist_ctl_t                   dctl;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // one operand pair into the shared unit
  always_comb begin
    dctl.first = !found_r;
    if (state_r == S_EDIST || state_r == S_EFET) begin
      ua_x = rpx_r; ua_y = rpy_r; ub_x = rex_r; ub_y = rey_r;
    end else begin
      ua_x = qx_r;  ua_y = qy_r;  ub_x = rpx_r; ub_y = rpy_r;
    end
  end

  fnps_dist u_dist (
    .clk  (clk),
    .ax   (ua_x),
    .ay   (ua_y),
    .bx   (ub_x),
    .by   (ub_y),
    .dsq  (dsq)
  );

  // memories
  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_ADD && pcount_r < PtCntBits'(MaxPoints)) begin
      px_mem[pcount_r[PtIdxBits-1:0]] <= in_coord_x;
      py_mem[pcount_r[PtIdxBits-1:0]] <= in_coord_y;
      pc_mem[pcount_r[PtIdxBits-1:0]] <= in_point_color;
    end
    if (accept && in_req_type == REQ_EXCL && ecount_r < ExCntBits'(MaxExcluded)) begin
      ex_mem[ecount_r[ExIdxBits-1:0]] <= in_coord_x;
      ey_mem[ecount_r[ExIdxBits-1:0]] <= in_coord_y;
    end
    if (state_r == S_FETCH) begin
      rpx_r <= px_mem[pi_r[PtIdxBits-1:0]];
      rpy_r <= py_mem[pi_r[PtIdxBits-1:0]];
      rpc_r <= pc_mem[pi_r[PtIdxBits-1:0]];
    end
    if (state_r == S_EFET) begin
      rex_r <= ex_mem[ej_r[ExIdxBits-1:0]];
      rey_r <= ey_mem[ej_r[ExIdxBits-1:0]];
    end
  end

  logic pass_pre;
  logic excl_hit;
  always_comb begin
    pass_pre = mask_r[color_class(rpc_r)] && (DistBits'(rmin_sq_r) < dsq) &&
               (dctl.first || dsq < best_d_r);
    excl_hit = dsq < DistBits'(rex_sq_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = (in_req_type == REQ_QUERY) ? S_FETCH : S_DONE;
      S_FETCH: state_nxt = (pi_r >= pcount_r) ? S_DONE : S_PDIST;
      S_PDIST: if (wait_r == 2'd3) begin
        if (!pass_pre) state_nxt = S_FETCH;
        else if (ecount_r == '0) state_nxt = S_FETCH;
        else state_nxt = S_EFET;
      end
      S_EFET:  state_nxt = S_EDIST;
      S_EDIST: if (wait_r == 2'd3) begin
        if (excl_hit || ej_r + 1'b1 >= ecount_r) state_nxt = S_FETCH;
        else state_nxt = S_EFET;
      end
      S_DONE:  state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pcount_r <= '0;
      ecount_r <= '0;
      radius_r <= ExclRadiusReset;
      found_r  <= 1'b0;
      wait_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) radius_r <= cfg_exclude_radius;
      wait_r <= (state_r == S_PDIST || state_r == S_EDIST) ? wait_r + 2'd1 : 2'd0;
      if (accept) begin
        found_r <= 1'b0;
        unique case (in_req_type)
          REQ_ADD:   if (pcount_r < PtCntBits'(MaxPoints)) pcount_r <= pcount_r + 1'b1;
          REQ_EXCL:  if (ecount_r < ExCntBits'(MaxExcluded)) ecount_r <= ecount_r + 1'b1;
          REQ_CLEAR: ecount_r <= '0;
          default:   ;
        endcase
      end
      if (state_r == S_PDIST && wait_r == 2'd3 && pass_pre && ecount_r == '0)
        found_r <= 1'b1;
      if (state_r == S_EDIST && wait_r == 2'd3 && !excl_hit && ej_r + 1'b1 >= ecount_r)
        found_r <= 1'b1;
    end
  end

  // request capture, scan indices and best point
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_req_type;
      qx_r      <= in_coord_x;
      qy_r      <= in_coord_y;
      mask_r    <= in_color_mask;
      rmin_sq_r <= in_min_radius * in_min_radius;
      rex_sq_r  <= radius_r * radius_r;
      if (in_req_type == REQ_ADD && pcount_r >= PtCntBits'(MaxPoints))
        o_status_r <= ST_FULL;
      else if (in_req_type == REQ_EXCL && ecount_r >= ExCntBits'(MaxExcluded))
        o_status_r <= ST_FULL;
      else
        o_status_r <= ST_OK;
      pi_r <= '0;
    end
    if (state_r == S_FETCH) pi_r <= pi_r + 1'b1;
    if (state_r == S_PDIST && wait_r == 2'd3) begin
      cand_d_r <= dsq;
      ej_r     <= '0;
      if (pass_pre && ecount_r == '0) begin
        best_d_r <= dsq; bx_r <= rpx_r; by_r <= rpy_r; bc_r <= rpc_r;
      end
    end
    if (state_r == S_EDIST && wait_r == 2'd3) begin
      ej_r <= ej_r + 1'b1;
      if (!excl_hit && ej_r + 1'b1 >= ecount_r) begin
        best_d_r <= cand_d_r; bx_r <= rpx_r; by_r <= rpy_r; bc_r <= rpc_r;
      end
    end
    if (state_r == S_DONE) begin
      if (req_r == REQ_QUERY && found_r) begin
        o_status_r <= ST_OK; o_x_r <= bx_r; o_y_r <= by_r; o_c_r <= bc_r;
      end else begin
        o_x_r <= '0; o_y_r <= '0; o_c_r <= '0;
        if (req_r == REQ_QUERY) o_status_r <= ST_NOTHING;
      end
    end
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_status     = o_status_r;
  assign out_near_x     = o_x_r;
  assign out_near_y     = o_y_r;
  assign out_near_color = o_c_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= PtCntBits'(MaxPoints) && ecount_r <= ExCntBits'(MaxExcluded))
    else $error("store count over depth");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("ready while result pending");
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_near_x == '0 && out_near_y == '0 && out_near_color == '0))
    else $error("non-zero payload on failed request");

endmodule

@@ tb/sv/tb_filtered_nearest_point_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_filtered_nearest_point_search
// self-checking bench: predicts every request's answer and checks each result
// ----------------------------------------------------------------------------
// Requests go out with random gaps, results are taken under random stall.
// A predictor keeps its own point table, exclusion list and radius and works
// out each answer when the request is accepted; a checker process compares
// each accepted result with the oldest prediction, field by field.
module tb_filtered_nearest_point_search;
  import fnps_pkg::*;

  typedef struct {
    logic [1:0]          kind;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic [6:0]          color;
    logic [11:0]         mask;
    logic [14:0]         rmin;
  } search_req_t;

  typedef struct {
    logic [1:0]          status;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic [6:0]          color;
  } search_res_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [14:0] cfg_exclude_radius;
  logic in_valid, in_stall;
  logic [1:0] in_req_type;
  logic signed [15:0] in_coord_x, in_coord_y;
  logic [6:0] in_point_color;
  logic [11:0] in_color_mask;
  logic [14:0] in_min_radius;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic signed [15:0] out_near_x, out_near_y;
  logic [6:0] out_near_color;

  filtered_nearest_point_search dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_exclude_radius(cfg_exclude_radius),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_point_color(in_point_color), .in_color_mask(in_color_mask),
    .in_min_radius(in_min_radius),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_near_x(out_near_x), .out_near_y(out_near_y),
    .out_near_color(out_near_color)
  );

  // predictor state
  logic signed [15:0] pt_x [MaxPoints];
  logic signed [15:0] pt_y [MaxPoints];
  logic [6:0]         pt_col [MaxPoints];
  int                 pt_cnt;
  logic signed [15:0] ex_x [MaxExcluded];
  logic signed [15:0] ex_y [MaxExcluded];
  int                 ex_cnt;
  logic [14:0]        radius_model;

  search_res_t expected_answers [$];
  int  mismatches;
  bit  steady;   // no idling on either side while set

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  initial begin
    #200ms;
    $display("tb_filtered_nearest_point_search: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] sq_dist(logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] bx, logic signed [15:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return 64'(dx * dx) + 64'(dy * dy);
  endfunction

  function automatic int class_of(logic [6:0] code);
    if (code <= 100 && code % 10 == 0) return code / 10;
    return 11;
  endfunction

  function automatic bit near_exclusion(logic signed [15:0] px, logic signed [15:0] py);
    logic [63:0] lim;
    lim = 64'(radius_model) * 64'(radius_model);
    for (int e = 0; e < ex_cnt; e++)
      if (sq_dist(px, py, ex_x[e], ex_y[e]) < lim) return 1'b1;
    return 1'b0;
  endfunction

  function automatic search_res_t predict_answer(search_req_t r);
    search_res_t a;
    logic [63:0] lim, best, d;
    bit found;
    int bi;
    a = '{ST_OK, 16'sd0, 16'sd0, 7'd0};
    case (r.kind)
      REQ_ADD: begin
        if (pt_cnt >= MaxPoints) a.status = ST_FULL;
        else begin
          pt_x[pt_cnt] = r.x; pt_y[pt_cnt] = r.y; pt_col[pt_cnt] = r.color;
          pt_cnt++;
        end
      end
      REQ_EXCL: begin
        if (ex_cnt >= MaxExcluded) a.status = ST_FULL;
        else begin
          ex_x[ex_cnt] = r.x; ex_y[ex_cnt] = r.y;
          ex_cnt++;
        end
      end
      REQ_CLEAR: ex_cnt = 0;
      default: begin
        lim = 64'(r.rmin) * 64'(r.rmin);
        best = 0; found = 0; bi = 0;
        for (int i = 0; i < pt_cnt; i++) begin
          if (!r.mask[class_of(pt_col[i])]) continue;
          d = sq_dist(r.x, r.y, pt_x[i], pt_y[i]);
          if (!(lim < d)) continue;
          if (found && !(d < best)) continue;
          if (near_exclusion(pt_x[i], pt_y[i])) continue;
          best = d; bi = i; found = 1;
        end
        if (found) a = '{ST_OK, pt_x[bi], pt_y[bi], pt_col[bi]};
        else a.status = ST_NOTHING;
      end
    endcase
    return a;
  endfunction

  task automatic send_request(search_req_t r);
    int g;
    bit ok;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_req_type = r.kind; in_coord_x = r.x; in_coord_y = r.y;
    in_point_color = r.color; in_color_mask = r.mask; in_min_radius = r.rmin;
    forever begin
      #1;
      ok = !in_stall;
      @(posedge clk);
      if (ok) break;
      @(negedge clk);
    end
    expected_answers.push_back(predict_answer(r));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_answers.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_radius(logic [14:0] v);
    drain_results();
    cfg_exclude_radius = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    radius_model = v;
  endtask

  function automatic search_req_t make_req(logic [1:0] k, int x, int y, int col,
                                           int mask, int rmin);
    search_req_t r;
    r.kind = k; r.x = 16'(x); r.y = 16'(y); r.color = 7'(col);
    r.mask = 12'(mask); r.rmin = 15'(rmin);
    return r;
  endfunction

  function automatic search_req_t random_req();
    search_req_t r;
    int p;
    p = $urandom_range(0, 99);
    r.kind = p < 25 ? REQ_ADD : p < 40 ? REQ_EXCL : p < 48 ? REQ_CLEAR : REQ_QUERY;
    // mostly a small neighbourhood so radii and exclusions bite
    if ($urandom_range(0, 3) == 0) begin
      r.x = 16'($urandom); r.y = 16'($urandom);
    end else begin
      r.x = 16'($signed($urandom_range(0, 800)) - 400);
      r.y = 16'($signed($urandom_range(0, 800)) - 400);
    end
    r.color = $urandom_range(0, 1) ? 7'($urandom_range(0, 10) * 10) : 7'($urandom);
    r.mask = $urandom_range(0, 4) == 0 ? 12'($urandom) | 12'hfff : 12'($urandom);
    r.rmin = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($urandom_range(0, 120));
    return r;
  endfunction

  // checker: result taken at the rising edge
  initial begin
    search_res_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result status=%0d x=%0d y=%0d col=%0d",
                     out_status, out_near_x, out_near_y, out_near_color);
        end else begin
          e = expected_answers.pop_front();
          if (out_status !== e.status || out_near_x !== e.x || out_near_y !== e.y ||
              out_near_color !== e.color) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp st=%0d x=%0d y=%0d col=%0d got st=%0d x=%0d y=%0d col=%0d",
                       e.status, e.x, e.y, e.color,
                       out_status, out_near_x, out_near_y, out_near_color);
          end
        end
      end
    end
  end

  // result side stall
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      g = pick_gap();
      if (g > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk);
    end
  end

  task automatic test_directed();
    // empty store, then extremes of coordinates and colour classes
    send_request(make_req(REQ_QUERY, 0, 0, 0, 'hfff, 0));
    send_request(make_req(REQ_ADD, -32768, -32768, 0, 0, 0));
    send_request(make_req(REQ_ADD, 32767, 32767, 100, 0, 0));
    send_request(make_req(REQ_ADD, 10, 10, 127, 0, 0));
    send_request(make_req(REQ_ADD, 10, 10, 5, 0, 0));      // tie with previous
    send_request(make_req(REQ_ADD, 40, -20, 50, 0, 0));
    send_request(make_req(REQ_QUERY, 0, 0, 0, 0, 0));       // empty mask
    send_request(make_req(REQ_QUERY, 0, 0, 0, 'hfff, 0));
    send_request(make_req(REQ_QUERY, 32767, -32768, 0, 'h001, 0));
    send_request(make_req(REQ_QUERY, 0, 0, 0, 'h800, 0));
    send_request(make_req(REQ_QUERY, 0, 0, 0, 'hfff, 32767));
    send_request(make_req(REQ_QUERY, 10, 10, 0, 'hfff, 0));  // at zero distance: skipped
    send_request(make_req(REQ_EXCL, 12, 12, 0, 0, 0));
    send_request(make_req(REQ_QUERY, 0, 0, 0, 'hfff, 0));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_QUERY, 0, 0, 0, 'hfff, 0));
    // exclusion list full
    for (int i = 0; i <= MaxExcluded; i++)
      send_request(make_req(REQ_EXCL, 1000 + i, -1000, 0, 0, 0));
    send_request(make_req(REQ_QUERY, 1000, -1000, 0, 'hfff, 0));
    send_request(make_req(REQ_CLEAR, -1, -1, 127, 'hfff, 32767));
  endtask

  task automatic test_radius_extremes();
    write_radius(15'd0);
    send_request(make_req(REQ_EXCL, 10, 10, 0, 0, 0));
    send_request(make_req(REQ_QUERY, 0, 0, 0, 'hfff, 0));
    write_radius(15'h7fff);
    send_request(make_req(REQ_QUERY, 0, 0, 0, 'hfff, 0));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    write_radius(ExclRadiusReset);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_request(random_req());
  endtask

  task automatic test_idle_pause();
    // hold the sender until every answer is back, then send 60 random requests with no idling
    drain_results();
    steady = 1'b1;
    test_random(60);
    steady = 1'b0;
  endtask

  task automatic test_store_full();
    while (pt_cnt < MaxPoints)
      send_request(make_req(REQ_ADD, $urandom_range(0, 600) - 300,
                            $urandom_range(0, 600) - 300, $urandom_range(0, 127), 0, 0));
    send_request(make_req(REQ_ADD, 1, 2, 3, 0, 0));
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_exclude_radius = '0;
    in_valid = 1'b0; in_req_type = REQ_ADD; in_coord_x = '0; in_coord_y = '0;
    in_point_color = '0; in_color_mask = '0; in_min_radius = '0;
    pt_cnt = 0; ex_cnt = 0; radius_model = ExclRadiusReset;
    mismatches = 0; steady = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_radius_extremes();
    test_random(300);
    test_idle_pause();
    write_radius(15'($urandom_range(1, 200)));
    test_random(300);
    test_store_full();
    write_radius(15'h7fff);
    test_random(200);
    write_radius(15'd0);
    test_random(200);
    write_radius(15'($urandom));
    test_random(200);
    drain_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("tb_filtered_nearest_point_search: done, clean");
    else
      $display("tb_filtered_nearest_point_search: done, errors");
    $finish;
  end

endmodule
